// File: rtl/assert_macros.svh
// Assertion macros used by the count-min sketch top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME_CYCLE(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT_CYCLE(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_SAME_CYCLE(label, ante, cons)
`define ASSERT_NEXT_CYCLE(label, ante, cons)
`endif
`endif

// File: rtl/cms_pkg.sv
// Types and constants of the count-min sketch
package cms_pkg;

   localparam int ROWS_DEFAULT    = 3;
   localparam int COLUMNS_DEFAULT = 4096;

   localparam int KEY_W   = 64;
   localparam int SEED_W  = 64;
   localparam int COUNT_W = 16;
   localparam int CTR_W   = 32;

   localparam logic [63:0]      HASH_MULT   = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [CTR_W-1:0] COUNTER_MAX = {CTR_W{1'b1}};

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] operand;
   } hash_req_type;

endpackage

// File: rtl/cms_if.sv
// Request and response channel interfaces of the count-min sketch
interface cms_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [cms_pkg::KEY_W-1:0]   flow_key;
   logic [cms_pkg::COUNT_W-1:0] packet_count;

   modport source (output valid, mode, flow_key, packet_count, input ready);
   modport sink (input valid, mode, flow_key, packet_count, output ready);
endinterface

interface cms_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [cms_pkg::CTR_W-1:0] estimate;

   modport source (output valid, estimate, input ready);
   modport sink (input valid, estimate, output ready);
endinterface

// File: rtl/cms_hash.sv
// Iterative row hash: one shared 32x32 multiplier over six steps
module cms_hash #(
   parameter int COLUMNS = cms_pkg::COLUMNS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cms_pkg::hash_req_type       hash_req,
   output logic                        hash_done,
   output logic [$clog2(COLUMNS)-1:0]  hash_column
);

   localparam int CW = $clog2(COLUMNS);

   localparam logic [2:0] STEP_LL    = 3'd0;
   localparam logic [2:0] STEP_HL    = 3'd1;
   localparam logic [2:0] STEP_LH    = 3'd2;
   localparam logic [2:0] STEP_ADD   = 3'd3;
   localparam logic [2:0] STEP_SCALE = 3'd4;
   localparam logic [2:0] STEP_DONE  = 3'd5;

   logic [63:0] x_ff, x_in;
   logic [2:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic [31:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] op_a, op_b;

   always_comb begin
      case (step_ff)
         STEP_LL: begin
            op_a = x_ff[31:0];
            op_b = cms_pkg::HASH_MULT[31:0];
         end
         STEP_HL: begin
            op_a = x_ff[63:32];
            op_b = cms_pkg::HASH_MULT[31:0];
         end
         STEP_LH: begin
            op_a = x_ff[31:0];
            op_b = cms_pkg::HASH_MULT[63:32];
         end
         STEP_SCALE: begin
            op_a = acc_ff;
            op_b = 32'(COLUMNS);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = 64'(op_a) * 64'(op_b);

   always_comb begin
      x_in    = x_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      acc_in  = acc_ff;
      if (busy_ff) begin
         step_in = step_ff + 3'd1;
         case (step_ff)
            STEP_HL:  acc_in = prod_ff[63:32];
            STEP_LH:  acc_in = acc_ff + prod_ff[31:0];
            STEP_ADD: acc_in = acc_ff + prod_ff[31:0];
            default:  acc_in = acc_ff;
         endcase
         if (step_ff == STEP_DONE) begin
            busy_in = 1'b0;
         end
      end else if (hash_req.start) begin
         x_in    = hash_req.operand;
         step_in = STEP_LL;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign hash_done   = busy_ff && (step_ff == STEP_DONE);
   assign hash_column = prod_ff[32 +: CW];

endmodule

// File: rtl/cms_ram.sv
// Counter memory: one write port, one registered read port
module cms_ram #(
   parameter int DEPTH = cms_pkg::ROWS_DEFAULT * cms_pkg::COLUMNS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [cms_pkg::CTR_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [cms_pkg::CTR_W-1:0] rd_data
);

   logic [cms_pkg::CTR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/count_min_sketch.sv
// Count-min sketch top level: sequencer, seed register and response word.
// Per row the key goes through the shared hash multiplier, then a memory read
// and an apply; a query then adds a done state that delivers the response word.
// One word at a time; the next word is taken while a response waits.
// After reset a clearing pass writes ROWS*COLUMNS (12288) counters, one a cycle.
`include "assert_macros.svh"

module count_min_sketch #(
   parameter int ROWS    = cms_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = cms_pkg::COLUMNS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   cms_req_if.sink                    req_chan,
   cms_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [cms_pkg::SEED_W-1:0] csr_wr_data
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_HASH  = 6'b000100,
      ST_READ  = 6'b001000,
      ST_APPLY = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type                  state_ff, state_in;
   logic [cms_pkg::SEED_W-1:0] seed_ff, seed_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [RW-1:0]              row_ff, row_in;
   logic [AW-1:0]              base_ff, base_in;
   logic [AW-1:0]              addr_ff, addr_in;
   logic                       mode_ff, mode_in;
   logic [cms_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [cms_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [cms_pkg::CTR_W-1:0]  least_ff, least_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cms_pkg::CTR_W-1:0]  est_ff, est_in;

   cms_pkg::hash_req_type      hash_req;
   logic                       hash_done;
   logic [CW-1:0]              hash_column;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [cms_pkg::CTR_W-1:0]  ram_wr_data;
   logic                       ram_rd_en;
   logic [cms_pkg::CTR_W-1:0]  ram_rd_data;

   logic                       accept;
   logic                       last_row;
   logic                       slot_free;
   logic [cms_pkg::CTR_W:0]    sum;
   logic [cms_pkg::CTR_W-1:0]  sat_sum;

   cms_hash #(
      .COLUMNS (COLUMNS)
   ) u_hash (
      .clock       (clock),
      .reset       (reset),
      .hash_req    (hash_req),
      .hash_done   (hash_done),
      .hash_column (hash_column)
   );

   cms_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign accept            = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.estimate = est_ff;

   assign last_row  = (row_ff == RW'(ROWS - 1));
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign sum       = {1'b0, ram_rd_data} + (cms_pkg::CTR_W + 1)'(count_ff);
   assign sat_sum   = sum[cms_pkg::CTR_W] ? cms_pkg::COUNTER_MAX : sum[cms_pkg::CTR_W-1:0];
   assign ram_rd_en = (state_ff == ST_READ);

   always_comb begin
      hash_req.start   = 1'b0;
      hash_req.operand = key_ff ^ (seed_ff + cms_pkg::SEED_W'(row_ff) + 64'd1);
      if (state_ff == ST_IDLE) begin
         hash_req.start   = accept;
         hash_req.operand = req_chan.flow_key ^ seed_ff;
      end else if (state_ff == ST_APPLY) begin
         hash_req.start   = !last_row;
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = sat_sum;
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else if (state_ff == ST_APPLY && mode_ff == cms_pkg::MODE_UPDATE) begin
         ram_wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      clr_in       = clr_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      least_in     = least_ff;
      est_in       = est_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_chan.mode;
               key_in   = req_chan.flow_key;
               count_in = req_chan.packet_count;
               row_in   = '0;
               base_in  = '0;
               least_in = cms_pkg::COUNTER_MAX;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               addr_in  = base_ff + AW'(hash_column);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (mode_ff == cms_pkg::MODE_QUERY && ram_rd_data < least_ff) begin
               least_in = ram_rd_data;
            end
            if (last_row) begin
               state_in = (mode_ff == cms_pkg::MODE_QUERY) ? ST_DONE : ST_IDLE;
            end else begin
               row_in   = row_ff + RW'(1);
               base_in  = base_ff + AW'(COLUMNS);
               state_in = ST_HASH;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               est_in       = least_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff   <= row_in;
      base_ff  <= base_in;
      addr_ff  <= addr_in;
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      count_ff <= count_in;
      least_ff <= least_in;
      est_ff   <= est_in;
   end

   `ASSERT_SAME_CYCLE(a_hash_done_in_hash, hash_done, state_ff == ST_HASH)
   `ASSERT_SAME_CYCLE(a_wr_addr_in_range, ram_wr_en, 32'(ram_wr_addr) < DEPTH)
   `ASSERT_NEXT_CYCLE(a_query_delivers, (state_ff == ST_DONE) && slot_free, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
